// ===== rtl/olist_pkg.sv =====
// ---------------------------------------------------------------------------
// Ordered list engine package
// Shared constants, command and status codes, and control types.
// ---------------------------------------------------------------------------
package olist_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int WORD_WIDTH_DEF = 32;

  localparam int OP_W  = 3;
  localparam int POS_W = 7;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;
  localparam int CNT_OUT_W = 7;

  // The two spare codes are accepted and leave the list unchanged.
  typedef enum logic [OP_W-1:0] {
    OP_INSERT    = 3'd0,
    OP_DEL_POS   = 3'd1,
    OP_LOCATE    = 3'd2,
    OP_DEL_MATCH = 3'd3,
    OP_DEL_ALL   = 3'd4,
    OP_CLEAR     = 3'd5,
    OP_SPARE6    = 3'd6,
    OP_SPARE7    = 3'd7
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_POS   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } st_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_RESULT
  } fsm_t;

  // Row control broadcast to every cell each cycle.
  typedef enum logic [1:0] {
    RING_HOLD,
    RING_INSERT,
    RING_KEEP,
    RING_DROP
  } ring_t;

endpackage

// ===== rtl/olist_cell.sv =====
// ---------------------------------------------------------------------------
// Ordered list cell
// Holds one list entry and picks its next word from its neighbors, the
// head of the row or the word being inserted.
// ---------------------------------------------------------------------------
module olist_cell #(
  parameter int WORD_WIDTH = olist_pkg::WORD_WIDTH_DEF,
  parameter int IDX_W      = 6,
  parameter int INDEX      = 0
) (
  input  logic                   clk,
  input  olist_pkg::ring_t       ring_mode,
  input  logic [IDX_W-1:0]       ring_idx,
  input  logic [WORD_WIDTH-1:0]  left,
  input  logic [WORD_WIDTH-1:0]  right,
  input  logic [WORD_WIDTH-1:0]  head,
  input  logic [WORD_WIDTH-1:0]  load_word,
  output logic [WORD_WIDTH-1:0]  word
);
  import olist_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [WORD_WIDTH-1:0] word_next;

  // During a rotation the tail cell takes the head word, and every cell
  // below the tail takes the word from its right neighbor.
  always_comb begin
    word_next = word;
    case (ring_mode)
      RING_INSERT: begin
        if (MY_IDX == ring_idx) begin
          word_next = load_word;
        end else if (MY_IDX > ring_idx) begin
          word_next = left;
        end
      end
      RING_KEEP: begin
        if (MY_IDX < ring_idx) begin
          word_next = right;
        end else if (MY_IDX == ring_idx) begin
          word_next = head;
        end
      end
      RING_DROP: begin
        if (MY_IDX < ring_idx) begin
          word_next = right;
        end
      end
      default: word_next = word;
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

// ===== rtl/olist_seq.sv =====
// ---------------------------------------------------------------------------
// Ordered list sequencer
// Takes requests, checks positions, steers the cell row through inserts
// and rotations, and assembles the result.
// ---------------------------------------------------------------------------
module olist_seq #(
  parameter int CAPACITY   = olist_pkg::CAPACITY_DEF,
  parameter int WORD_WIDTH = olist_pkg::WORD_WIDTH_DEF,
  parameter int IDX_W      = $clog2(CAPACITY)
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [olist_pkg::OP_W-1:0]            opcode,
  input  logic [olist_pkg::POS_W-1:0]           position,
  input  logic signed [olist_pkg::VAL_W-1:0]    value,
  input  logic [WORD_WIDTH-1:0]                 head,
  output logic                                  busy,
  output logic                                  done,
  output olist_pkg::ring_t                      ring_mode,
  output logic [IDX_W-1:0]                      ring_idx,
  output logic [WORD_WIDTH-1:0]                 load_word,
  output logic [olist_pkg::ST_W-1:0]            status,
  output logic [olist_pkg::CNT_OUT_W-1:0]       found_position,
  output logic signed [olist_pkg::VAL_W-1:0]    removed_value,
  output logic [olist_pkg::CNT_OUT_W-1:0]       removed_count,
  output logic [olist_pkg::CNT_OUT_W-1:0]       list_length
);
  import olist_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  fsm_t                          state, state_next;
  logic [OP_W-1:0]               cmd_op, cmd_op_next;
  logic [POS_W-1:0]              cmd_pos, cmd_pos_next;
  logic signed [WORD_WIDTH-1:0]  cmd_word, cmd_word_next;
  logic [CNT_W-1:0]              count, count_next;
  logic [CNT_W-1:0]              scan_len, scan_len_next;
  logic [CNT_W-1:0]              step, step_next;
  logic                          hit, hit_next;
  logic [CNT_W-1:0]              found_pos, found_pos_next;
  logic signed [WORD_WIDTH-1:0]  rem_word, rem_word_next;
  logic [CNT_W-1:0]              rem_cnt, rem_cnt_next;
  st_t                           res_status, res_status_next;

  logic [CMP_W-1:0] pos_x, cnt_x;
  logic ins_bad, del_bad, list_full, list_empty, go_scan;
  logic hit_now, first_hit, drop, step_last;

  assign pos_x      = CMP_W'(cmd_pos);
  assign cnt_x      = CMP_W'(count);
  assign ins_bad    = (pos_x == '0) || (pos_x > cnt_x + CMP_W'(1));
  assign del_bad    = (pos_x == '0) || (pos_x > cnt_x);
  assign list_full  = (cnt_x >= CMP_W'(CAPACITY));
  assign list_empty = (count == '0);
  assign go_scan    = ((cmd_op == OP_DEL_POS) && !del_bad) ||
                      (((cmd_op == OP_LOCATE) || (cmd_op == OP_DEL_MATCH) ||
                        (cmd_op == OP_DEL_ALL)) && !list_empty);

  assign hit_now   = (head == cmd_word);
  assign first_hit = hit_now && !hit;
  assign step_last = (step == scan_len - CNT_W'(1));

  always_comb begin
    case (cmd_op)
      OP_DEL_POS:   drop = (CMP_W'(step) == pos_x - CMP_W'(1));
      OP_DEL_MATCH: drop = first_hit;
      OP_DEL_ALL:   drop = hit_now;
      default:      drop = 1'b0;
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (start) state_next = S_CHECK;
      S_CHECK:  state_next = go_scan ? S_SCAN : S_RESULT;
      S_SCAN:   if (step_last) state_next = S_RESULT;
      S_RESULT: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Datapath and row control.
  always_comb begin
    cmd_op_next     = cmd_op;
    cmd_pos_next    = cmd_pos;
    cmd_word_next   = cmd_word;
    count_next      = count;
    scan_len_next   = scan_len;
    step_next       = step;
    hit_next        = hit;
    found_pos_next  = found_pos;
    rem_word_next   = rem_word;
    rem_cnt_next    = rem_cnt;
    res_status_next = res_status;
    ring_mode       = RING_HOLD;
    ring_idx        = '0;
    load_word       = cmd_word;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd_op_next     = opcode;
          cmd_pos_next    = position;
          cmd_word_next   = WORD_WIDTH'(value);
          scan_len_next   = count;
          step_next       = '0;
          hit_next        = 1'b0;
          found_pos_next  = '0;
          rem_word_next   = '0;
          rem_cnt_next    = '0;
          res_status_next = ST_OK;
        end
      end
      S_CHECK: begin
        case (cmd_op)
          OP_INSERT: begin
            if (ins_bad) begin
              res_status_next = ST_BAD_POS;
            end else if (list_full) begin
              res_status_next = ST_FULL;
            end else begin
              ring_mode  = RING_INSERT;
              ring_idx   = IDX_W'(pos_x - CMP_W'(1));
              count_next = count + CNT_W'(1);
            end
          end
          OP_DEL_POS: begin
            if (del_bad) res_status_next = ST_BAD_POS;
          end
          OP_LOCATE, OP_DEL_MATCH, OP_DEL_ALL: begin
            if (list_empty) res_status_next = ST_NOT_FOUND;
          end
          OP_CLEAR: begin
            rem_cnt_next = count;
            count_next   = '0;
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        // The row rotates once per cycle; the head word is examined and
        // either moved to the tail or dropped.
        ring_mode = drop ? RING_DROP : RING_KEEP;
        ring_idx  = IDX_W'(count - CNT_W'(1));
        step_next = step + CNT_W'(1);
        if (drop) begin
          count_next   = count - CNT_W'(1);
          rem_cnt_next = rem_cnt + CNT_W'(1);
        end
        if (drop && (cmd_op == OP_DEL_POS)) rem_word_next = head;
        if (first_hit) begin
          hit_next = 1'b1;
          if (cmd_op == OP_LOCATE) found_pos_next = step + CNT_W'(1);
        end
        if (step_last) begin
          case (cmd_op)
            OP_LOCATE, OP_DEL_MATCH:
              res_status_next = (hit || hit_now) ? ST_OK : ST_NOT_FOUND;
            OP_DEL_ALL:
              res_status_next = ((rem_cnt != '0) || hit_now) ? ST_OK : ST_NOT_FOUND;
            default:
              res_status_next = ST_OK;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    cmd_op     <= cmd_op_next;
    cmd_pos    <= cmd_pos_next;
    cmd_word   <= cmd_word_next;
    scan_len   <= scan_len_next;
    step       <= step_next;
    hit        <= hit_next;
    found_pos  <= found_pos_next;
    rem_word   <= rem_word_next;
    rem_cnt    <= rem_cnt_next;
    res_status <= res_status_next;
  end

  assign busy           = (state != S_IDLE);
  assign done           = (state == S_RESULT);
  assign status         = res_status;
  assign found_position = CNT_OUT_W'(found_pos);
  assign removed_value  = VAL_W'(rem_word);
  assign removed_count  = CNT_OUT_W'(rem_cnt);
  assign list_length    = CNT_OUT_W'(count);

endmodule

// ===== rtl/ordered_list_engine_core.sv =====
// Insert, clear, unused codes and rejected requests go from acceptance through
// the check state to the result state; locate, delete at position and both match
// deletes rotate the cell row once through the list in a scan state between.
// A request is taken only in idle, after the last result; one full rotation of
// the row sets how much longer the rotating requests take.
// Reset (synchronous) empties the list and returns to idle; the result strobe
// is a single cycle and the receiver cannot stall it.
// ---------------------------------------------------------------------------
// Ordered list engine core
// A fixed-capacity ordered list held in a row of cells, with insert, delete,
// locate, match deletion and clear requests.
// ---------------------------------------------------------------------------
module ordered_list_engine_core #(
  parameter int CAPACITY   = olist_pkg::CAPACITY_DEF,
  parameter int WORD_WIDTH = olist_pkg::WORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [olist_pkg::OP_W-1:0]          opcode,
  input  logic [olist_pkg::POS_W-1:0]         position,
  input  logic signed [olist_pkg::VAL_W-1:0]  value,
  output logic                                busy,
  output logic                                done,
  output logic [olist_pkg::ST_W-1:0]          status,
  output logic [olist_pkg::CNT_OUT_W-1:0]     found_position,
  output logic signed [olist_pkg::VAL_W-1:0]  removed_value,
  output logic [olist_pkg::CNT_OUT_W-1:0]     removed_count,
  output logic [olist_pkg::CNT_OUT_W-1:0]     list_length
);
  import olist_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);

  ring_t                 ring_mode;
  logic [IDX_W-1:0]      ring_idx;
  logic [WORD_WIDTH-1:0] load_word;
  logic [WORD_WIDTH-1:0] words [CAPACITY];

  olist_seq #(
    .CAPACITY   (CAPACITY),
    .WORD_WIDTH (WORD_WIDTH),
    .IDX_W      (IDX_W)
  ) u_seq (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .opcode         (opcode),
    .position       (position),
    .value          (value),
    .head           (words[0]),
    .busy           (busy),
    .done           (done),
    .ring_mode      (ring_mode),
    .ring_idx       (ring_idx),
    .load_word      (load_word),
    .status         (status),
    .found_position (found_position),
    .removed_value  (removed_value),
    .removed_count  (removed_count),
    .list_length    (list_length)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_row
    logic [WORD_WIDTH-1:0] left_word, right_word;

    if (i == 0) begin : g_first
      assign left_word = '0;
    end else begin : g_left
      assign left_word = words[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_word = '0;
    end else begin : g_right
      assign right_word = words[i+1];
    end

    olist_cell #(
      .WORD_WIDTH (WORD_WIDTH),
      .IDX_W      (IDX_W),
      .INDEX      (i)
    ) u_entry (
      .clk       (clk),
      .ring_mode (ring_mode),
      .ring_idx  (ring_idx),
      .left      (left_word),
      .right     (right_word),
      .head      (words[0]),
      .load_word (load_word),
      .word      (words[i])
    );
  end

endmodule

// ===== rtl/olist_chk.sv =====
// ---------------------------------------------------------------------------
// Ordered list engine checker
// Port-level checks on request acceptance, the result strobe and status.
// ---------------------------------------------------------------------------
module olist_chk #(
  parameter int CAPACITY = olist_pkg::CAPACITY_DEF
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             start,
  input logic                             busy,
  input logic                             done,
  input logic [olist_pkg::ST_W-1:0]       status,
  input logic [olist_pkg::CNT_OUT_W-1:0]  list_length
);
  import olist_pkg::*;

  // A result always belongs to a request still in progress.
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe outside a request");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted request did not start");

  a_full_len: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_FULL)) |-> (list_length == CNT_OUT_W'(CAPACITY)))
    else $error("list full reported below capacity");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!busy && (list_length == '0)))
    else $error("reset did not empty the list");

endmodule

bind ordered_list_engine_core olist_chk #(
  .CAPACITY (CAPACITY)
) u_olist_chk (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .status      (status),
  .list_length (list_length)
);

// ===== test/ordered_list_engine_core_test.sv =====
// ---------------------------------------------------------------------------
// Ordered list engine core testbench
// Drives insert, delete, locate, match deletion and clear requests through
// the start/busy handshake and checks every result strobe against a shadow
// list kept in a SystemVerilog queue. Directed corner requests come first,
// then random requests, with up to three fills of the list to capacity.
// ---------------------------------------------------------------------------
module ordered_list_engine_core_test;
  import olist_pkg::*;

  localparam int LIST_CAPACITY = CAPACITY_DEF;
  localparam int RANDOM_REQUESTS = 500;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = LIST_CAPACITY + 20;

  typedef struct {
    logic [OP_W-1:0]         op;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] val;
    bit                      drain;
  } command_t;

  typedef struct {
    st_t                         status;
    logic [CNT_OUT_W-1:0]        found_position;
    logic signed [VAL_W-1:0]     removed_value;
    logic [CNT_OUT_W-1:0]        removed_count;
    logic [CNT_OUT_W-1:0]        list_length;
  } outcome_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        start = 1'b0;
  logic [OP_W-1:0]             opcode = '0;
  logic [POS_W-1:0]            position = '0;
  logic signed [VAL_W-1:0]     value = '0;
  logic                        busy;
  logic                        done;
  logic [ST_W-1:0]             status;
  logic [CNT_OUT_W-1:0]        found_position;
  logic signed [VAL_W-1:0]     removed_value;
  logic [CNT_OUT_W-1:0]        removed_count;
  logic [CNT_OUT_W-1:0]        list_length;

  command_t                pending_requests[$];
  outcome_t                expected_results[$];
  logic signed [VAL_W-1:0] plan_list[$];
  logic signed [VAL_W-1:0] shadow_list[$];
  command_t                active_request;

  int error_count = 0;
  int planned_count = 0;
  int requests_sent = 0;
  int results_seen = 0;
  int stall_cycles = 0;
  int full_rejects = 0;
  int bad_positions = 0;
  int value_misses = 0;
  int peak_length = 0;

  ordered_list_engine_core dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .opcode         (opcode),
    .position       (position),
    .value          (value),
    .busy           (busy),
    .done           (done),
    .status         (status),
    .found_position (found_position),
    .removed_value  (removed_value),
    .removed_count  (removed_count),
    .list_length    (list_length)
  );

  always #10 clk = ~clk;

  // Applies one request to a list and returns the result the block must give.
  function automatic outcome_t apply_command(ref logic signed [VAL_W-1:0] words[$],
                                             input command_t c);
    outcome_t                r;
    logic signed [VAL_W-1:0] kept[$];
    int                      n;
    int                      pos;
    int                      hit;
    r.status = ST_OK;
    r.found_position = '0;
    r.removed_value = '0;
    r.removed_count = '0;
    n = words.size();
    pos = int'(c.pos);
    hit = 0;
    if (c.op == OP_LOCATE || c.op == OP_DEL_MATCH) begin
      for (int k = 0; k < n; k++) begin
        if (words[k] == c.val) begin
          hit = k + 1;
          break;
        end
      end
    end
    case (c.op)
      OP_INSERT: begin
        if (pos < 1 || pos > n + 1) r.status = ST_BAD_POS;
        else if (n >= LIST_CAPACITY) r.status = ST_FULL;
        else words.insert(pos - 1, c.val);
      end
      OP_DEL_POS: begin
        if (pos < 1 || pos > n) begin
          r.status = ST_BAD_POS;
        end else begin
          r.removed_value = words[pos - 1];
          r.removed_count = CNT_OUT_W'(1);
          words.delete(pos - 1);
        end
      end
      OP_LOCATE: begin
        r.found_position = hit[CNT_OUT_W-1:0];
        if (hit == 0) r.status = ST_NOT_FOUND;
      end
      OP_DEL_MATCH: begin
        if (hit == 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          words.delete(hit - 1);
          r.removed_count = CNT_OUT_W'(1);
        end
      end
      OP_DEL_ALL: begin
        foreach (words[k]) begin
          if (words[k] != c.val) kept.push_back(words[k]);
        end
        r.removed_count = CNT_OUT_W'(n - kept.size());
        if (kept.size() == n) r.status = ST_NOT_FOUND;
        words = kept;
      end
      OP_CLEAR: begin
        r.removed_count = CNT_OUT_W'(n);
        words.delete();
      end
      default: ;
    endcase
    r.list_length = CNT_OUT_W'(words.size());
    return r;
  endfunction

  task automatic queue_command(input logic [OP_W-1:0] op, input int pos,
                               input logic signed [VAL_W-1:0] val);
    command_t c;
    outcome_t unused;
    c.op = op;
    c.pos = POS_W'(pos);
    c.val = val;
    c.drain = 1'b0;
    pending_requests.push_back(c);
    unused = apply_command(plan_list, c);
    planned_count++;
  endtask

  // Mostly values already in the list or from a tiny pool, so matches and
  // duplicates are common; the rest spans the whole word.
  function automatic logic signed [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (plan_list.size() > 0 && r < 55) return plan_list[$urandom_range(plan_list.size() - 1)];
    if (r < 80) return VAL_W'(int'($urandom_range(6)) - 3);
    return $urandom;
  endfunction

  function automatic logic signed [VAL_W-1:0] fresh_value();
    if ($urandom_range(99) < 40) return VAL_W'(int'($urandom_range(6)) - 3);
    return $urandom;
  endfunction

  // Driver: a request is taken at an edge where start is high and busy low.
  always @(posedge clk) begin
    outcome_t predicted;
    bit       quiet;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predicted = apply_command(shadow_list, active_request);
        expected_results.push_back(predicted);
        requests_sent++;
        if (predicted.status == ST_FULL) full_rejects++;
        if (predicted.status == ST_BAD_POS) bad_positions++;
        if (predicted.status == ST_NOT_FOUND) value_misses++;
        if (int'(predicted.list_length) > peak_length)
          peak_length = int'(predicted.list_length);
      end
      if (!start || !busy) begin
        quiet = requests_sent >= 120 && requests_sent < 220;
        if (pending_requests.size() > 0 && pending_requests[0].drain) begin
          // Hold off until every outstanding result has come back.
          if (expected_results.size() == 0) void'(pending_requests.pop_front());
          start <= 1'b0;
        end else if (pending_requests.size() == 0 || (!quiet && $urandom_range(99) < 17)) begin
          start <= 1'b0;
        end else begin
          active_request = pending_requests.pop_front();
          opcode <= active_request.op;
          position <= active_request.pos;
          value <= active_request.val;
          start <= 1'b1;
        end
      end
    end
  end

  // Monitor: every result strobe is checked against the oldest prediction.
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && done) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding: status %0d, length %0d",
               status, list_length);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (status != want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          error_count++;
        end
        if (found_position != want.found_position) begin
          $error("found_position: expected %0d, got %0d", want.found_position, found_position);
          error_count++;
        end
        if (removed_value != want.removed_value) begin
          $error("removed_value: expected %0d, got %0d", want.removed_value, removed_value);
          error_count++;
        end
        if (removed_count != want.removed_count) begin
          $error("removed_count: expected %0d, got %0d", want.removed_count, removed_count);
          error_count++;
        end
        if (list_length != want.list_length) begin
          $error("list_length: expected %0d, got %0d", want.list_length, list_length);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles where neither a request nor a result moves.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Timed out after %0d cycles with no progress.", stall_cycles);
      $display("** ordered_list_engine_core: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    command_t marker;
    int       len;
    int       pick;
    int       fills;
    bit       drained;
    fills = 0;
    drained = 0;

    // Empty-list corners, signed extremes, duplicates and unused codes.
    queue_command(OP_LOCATE, 0, 32'sd5);
    queue_command(OP_DEL_POS, 1, 32'sd0);
    queue_command(OP_DEL_MATCH, 0, 32'sd0);
    queue_command(OP_DEL_ALL, 0, 32'sd0);
    queue_command(OP_INSERT, 0, 32'sd1);
    queue_command(OP_INSERT, 2, 32'sd1);
    queue_command(OP_INSERT, 1, 32'sh8000_0000);
    queue_command(OP_INSERT, 2, 32'sh7fff_ffff);
    queue_command(OP_INSERT, 1, -32'sd1);
    queue_command(OP_INSERT, 2, 32'sd5);
    queue_command(OP_INSERT, 5, 32'sd5);
    queue_command(OP_INSERT, 127, 32'sd9);
    queue_command(OP_LOCATE, 0, 32'sd5);
    queue_command(OP_LOCATE, 0, 32'sh8000_0000);
    queue_command(OP_DEL_ALL, 0, 32'sd5);
    queue_command(OP_DEL_MATCH, 0, 32'sh7fff_ffff);
    queue_command(OP_DEL_POS, 2, 32'sd0);
    queue_command(OP_DEL_POS, 65, 32'sd0);
    queue_command(OP_SPARE6, 65, 32'sh7fff_ffff);
    queue_command(OP_SPARE7, 127, -32'sd1);
    queue_command(OP_DEL_POS, 1, 32'sd0);
    queue_command(OP_INSERT, 1, 32'sd0);
    queue_command(OP_CLEAR, 0, 32'sd0);
    queue_command(OP_CLEAR, 127, -32'sd1);

    while (planned_count < RANDOM_REQUESTS) begin
      len = plan_list.size();
      pick = $urandom_range(99);
      if (!drained && planned_count >= RANDOM_REQUESTS / 2) begin
        marker.op = OP_CLEAR;
        marker.pos = '0;
        marker.val = '0;
        marker.drain = 1'b1;
        pending_requests.push_back(marker);
        drained = 1;
      end
      if (pick < 4 && fills < 3) begin
        // Fill to capacity, then push once more into the full list.
        while (plan_list.size() < LIST_CAPACITY)
          queue_command(OP_INSERT, plan_list.size() + 1, fresh_value());
        queue_command(OP_INSERT, $urandom_range(1, LIST_CAPACITY + 1), fresh_value());
        fills++;
      end else if (pick < 40) begin
        if ($urandom_range(9) == 0)
          queue_command(OP_INSERT, $urandom_range(1) ? 0 : $urandom_range(len + 2, 127),
                        fresh_value());
        else
          queue_command(OP_INSERT, $urandom_range(1, len + 1), fresh_value());
      end else if (pick < 56) begin
        if (len == 0 || $urandom_range(9) == 0)
          queue_command(OP_DEL_POS, $urandom_range(1) ? 0 : $urandom_range(len + 1, 127),
                        fresh_value());
        else
          queue_command(OP_DEL_POS, $urandom_range(1, len), fresh_value());
      end else if (pick < 68) begin
        queue_command(OP_LOCATE, $urandom_range(127), pick_value());
      end else if (pick < 78) begin
        queue_command(OP_DEL_MATCH, $urandom_range(127), pick_value());
      end else if (pick < 86) begin
        queue_command(OP_DEL_ALL, $urandom_range(127), pick_value());
      end else if (pick < 88) begin
        queue_command(OP_CLEAR, $urandom_range(127), $urandom);
      end else if (pick < 90) begin
        queue_command($urandom_range(1) ? OP_SPARE6 : OP_SPARE7, $urandom_range(127),
                      $urandom);
      end else begin
        // A fresh list: clear, then append a handful of words.
        queue_command(OP_CLEAR, 0, 32'sd0);
        repeat ($urandom_range(1, 12))
          queue_command(OP_INSERT, plan_list.size() + 1, fresh_value());
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pending_requests.size() != 0 || start || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d requests with %0d results; peak list length %0d.",
             requests_sent, results_seen, peak_length);
    $display("Rejections seen: %0d full list, %0d bad position, %0d value missing.",
             full_rejects, bad_positions, value_misses);
    if (error_count == 0) begin
      $display("** ordered_list_engine_core: PASSED **");
    end else begin
      $display("** ordered_list_engine_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/olist_pkg.sv
rtl/olist_cell.sv
rtl/olist_seq.sv
rtl/ordered_list_engine_core.sv
rtl/olist_chk.sv
test/ordered_list_engine_core_test.sv
